/* hdl/kwm_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_pkg: shared types for the k-way sorted merge
// request and result payloads, heap commands and sequencer state codes
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int MAX_LISTS_DEF = 16;
	localparam int CFG_W         = 5;
	localparam int VAL_W         = 32;
	localparam int OUT_ROW_W     = 4;

	localparam logic [CFG_W-1:0] NUM_LISTS_RST = 5'd16;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    exhausted;
	} in_item_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] out_value;
		logic [OUT_ROW_W-1:0]    out_row;
		logic                    merge_done;
	} out_item_t;

	typedef enum logic [1:0] {
		HOP_INSERT,
		HOP_REPLACE,
		HOP_POP
	} heap_op_t;

	typedef struct packed {
		logic     start;
		heap_op_t op;
	} heap_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} heap_stat_t;

	typedef enum logic [2:0] {
		H_IDLE,
		H_POP_RD,
		H_POP_LD,
		H_DN_RD,
		H_DN_C1,
		H_DN_C2,
		H_UP_RD,
		H_UP_C
	} heap_state_t;

	typedef enum logic [1:0] {
		T_IDLE,
		T_HEAP,
		T_EMIT
	} top_state_t;

endpackage
`default_nettype wire

/* hdl/k_way_sorted_merge.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// k_way_sorted_merge: merge of up to MAX_LISTS ascending streams
// min-heap of list heads, one result per merge step
// ----------------------------------------------------------------------------
// usage
//   item channel (valid/ready): a load phase takes one request per list in
//   list order 0..num_lists-1, then each request is the next element (or the
//   exhausted mark) of the list named by the last result's out_row
//   result channel (valid/ready): smallest head and its list, or merge_done
//   once every list is exhausted, after which loading starts over
//   cfg_we/cfg_data writes num_lists (0 acts as 1, above MAX_LISTS clamps)
// sequencing
//   one request at a time: item_ready is low while the heap sequencer runs
//   load request: a parent read and a compare per level climbed, no heap work
//   for an exhausted mark; the last one adds the emit state, result valid after it
//   merge request: child reads, child compare and carry compare per level
//   descended, a last-entry read and load first for an exhausted mark, then
//   the emit state; all around the single key comparator and registered read ports
// reset
//   back in the load phase, heap empty, num_lists = 16
// stall
//   a result waits in the output register; the next request is still taken,
//   and only its own result waits until the register is free
// ----------------------------------------------------------------------------
module k_way_sorted_merge import kwm_pkg::*; #(
	parameter int MAX_LISTS = MAX_LISTS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire in_item_t         item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output out_item_t             result
);

	localparam int ROW_W = $clog2(MAX_LISTS);
	localparam int CNT_W = $clog2(MAX_LISTS + 1);
	localparam int EFF_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	top_state_t state_q, state_d;

	logic [CFG_W-1:0] num_lists_q;
	logic [CNT_W-1:0] heap_count_q;
	logic [CFG_W-1:0] load_cnt_q;
	logic             merging_q;
	logic [ROW_W-1:0] exp_row_q;
	logic             pend_emit_q;
	logic             result_valid_q;
	out_item_t        result_q;

	// heap sequencer interface
	heap_req_t               hreq;
	heap_stat_t              hstat;
	logic [ROW_W-1:0]        h_row;
	logic [CNT_W-1:0]        h_count;
	logic signed [VAL_W-1:0] root_value;
	logic [ROW_W-1:0]        root_row;

	logic [EFF_W-1:0] nl_ext, eff_lists;
	logic [CFG_W-1:0] load_next;
	logic             load_end;
	logic             can_ins;
	logic             accept;
	logic             emit_fire;

	// effective list count with clamping of out-of-range settings
	assign nl_ext    = EFF_W'(num_lists_q);
	assign eff_lists = (nl_ext == '0) ? EFF_W'(1) :
		(nl_ext > EFF_W'(MAX_LISTS)) ? EFF_W'(MAX_LISTS) : nl_ext;

	assign load_next = load_cnt_q + CFG_W'(1);
	assign load_end  = EFF_W'(load_next) >= eff_lists;
	assign can_ins   = !item.exhausted && (heap_count_q < CNT_W'(MAX_LISTS));

	assign item_ready = (state_q == T_IDLE);
	assign accept     = item_valid && item_ready;
	assign emit_fire  = (state_q == T_EMIT) && (!result_valid_q || result_ready);

	kwm_heap #(.MAX_LISTS(MAX_LISTS)) u_heap (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (hreq),
		.elem_value (item.value),
		.elem_row   (h_row),
		.count      (h_count),
		.stat       (hstat),
		.root_value (root_value),
		.root_row   (root_row)
	);

	// phase control and heap command issue
	always_comb begin
		state_d    = state_q;
		hreq.start = 1'b0;
		hreq.op    = HOP_INSERT;
		h_row      = merging_q ? exp_row_q : ROW_W'(load_cnt_q);
		h_count    = heap_count_q;
		case (state_q)
			T_IDLE: begin
				if (accept) begin
					if (!merging_q) begin
						if (can_ins) begin
							hreq.start = 1'b1;
							state_d    = T_HEAP;
						end else if (load_end) begin
							state_d = T_EMIT;
						end
					end else if (heap_count_q != '0) begin
						hreq.start = 1'b1;
						if (item.exhausted) begin
							// drop the root, last entry refills it
							hreq.op = HOP_POP;
							h_count = heap_count_q - CNT_W'(1);
						end else begin
							hreq.op = HOP_REPLACE;
						end
						state_d = T_HEAP;
					end else begin
						state_d = T_EMIT;
					end
				end
			end
			T_HEAP: begin
				if (hstat.done) begin
					state_d = pend_emit_q ? T_EMIT : T_IDLE;
				end
			end
			T_EMIT: begin
				if (emit_fire) begin
					state_d = T_IDLE;
				end
			end
			default: state_d = T_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= T_IDLE;
			num_lists_q    <= NUM_LISTS_RST;
			heap_count_q   <= '0;
			load_cnt_q     <= '0;
			merging_q      <= 1'b0;
			exp_row_q      <= '0;
			pend_emit_q    <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				num_lists_q <= cfg_data;
			end
			if (accept) begin
				if (!merging_q) begin
					load_cnt_q  <= load_next;
					pend_emit_q <= load_end;
					if (can_ins) begin
						heap_count_q <= heap_count_q + CNT_W'(1);
					end
				end else begin
					pend_emit_q <= 1'b1;
					if (item.exhausted && (heap_count_q != '0)) begin
						heap_count_q <= heap_count_q - CNT_W'(1);
					end
				end
			end
			if (emit_fire) begin
				if (heap_count_q == '0) begin
					// all lists drained: back to loading
					merging_q  <= 1'b0;
					load_cnt_q <= '0;
					exp_row_q  <= '0;
				end else begin
					merging_q <= 1'b1;
					exp_row_q <= root_row;
				end
			end
			if (emit_fire) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (emit_fire) begin
			if (heap_count_q == '0) begin
				result_q.out_value  <= '0;
				result_q.out_row    <= '0;
				result_q.merge_done <= 1'b1;
			end else begin
				result_q.out_value  <= root_value;
				result_q.out_row    <= OUT_ROW_W'(root_row);
				result_q.merge_done <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	a_idle_heap_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == T_IDLE) |-> !hstat.busy)
		else $error("heap sequencer busy while accepting requests");

	a_done_in_heap: assert property (@(posedge clk) disable iff (!arst_n)
		hstat.done |-> (state_q == T_HEAP))
		else $error("heap done outside of heap wait");

	a_merge_step_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && merging_q && (heap_count_q != '0)) |=> (state_q == T_HEAP))
		else $error("merge request did not start the heap sequencer");

	a_done_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && (heap_count_q == '0)) |=>
		(!merging_q && (load_cnt_q == '0) && result_valid && result.merge_done))
		else $error("empty heap did not end the merge");
`endif

endmodule
`default_nettype wire

/* hdl/kwm_cmp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_cmp: heap key comparator
// key order is signed value first, then list number
// ----------------------------------------------------------------------------
module kwm_cmp import kwm_pkg::*; #(
	parameter int ROW_W = 4
) (
	input  wire logic signed [VAL_W-1:0] a_value,
	input  wire logic [ROW_W-1:0]        a_row,
	input  wire logic signed [VAL_W-1:0] b_value,
	input  wire logic [ROW_W-1:0]        b_row,
	output logic                         a_less
);

	assign a_less = (a_value < b_value) || ((a_value == b_value) && (a_row < b_row));

endmodule
`default_nettype wire

/* hdl/kwm_heap.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kwm_heap: min-heap store and sift sequencer
// hole-based sift-up and sift-down around one shared key comparator
// ----------------------------------------------------------------------------
module kwm_heap import kwm_pkg::*; #(
	parameter int MAX_LISTS = MAX_LISTS_DEF,
	localparam int ROW_W    = $clog2(MAX_LISTS),
	localparam int CNT_W    = $clog2(MAX_LISTS + 1)
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire heap_req_t               req,
	input  wire logic signed [VAL_W-1:0] elem_value,
	input  wire logic [ROW_W-1:0]        elem_row,
	input  wire logic [CNT_W-1:0]        count,
	output heap_stat_t                   stat,
	output logic signed [VAL_W-1:0]      root_value,
	output logic [ROW_W-1:0]             root_row
);

	localparam int IDX_W = ROW_W;
	localparam int ENT_W = VAL_W + ROW_W;
	localparam int LW    = IDX_W + 2;

	heap_state_t state_q, state_d;

	logic [ENT_W-1:0] mem [MAX_LISTS];
	logic [ENT_W-1:0] rd_a_q, rd_b_q;
	logic [ENT_W-1:0] carry_q, child_q, root_q;
	logic [IDX_W-1:0] child_idx_q;
	logic [IDX_W-1:0] i_q;
	logic [CNT_W-1:0] n_q;

	logic             we;
	logic [IDX_W-1:0] wa, ra, rb;
	logic [ENT_W-1:0] wd;
	logic             done;

	logic [ENT_W-1:0] cmp_a, cmp_b;
	logic             less;

	logic [LW-1:0]    l_ext, r_ext, n_ext;
	logic             has_l, has_r;
	logic [IDX_W-1:0] par;

	assign l_ext = {1'b0, i_q, 1'b1};
	assign r_ext = l_ext + LW'(1);
	assign n_ext = LW'(n_q);
	assign has_l = l_ext < n_ext;
	assign has_r = r_ext < n_ext;
	assign par   = (i_q - IDX_W'(1)) >> 1;

	kwm_cmp #(.ROW_W(ROW_W)) u_cmp (
		.a_value (cmp_a[ENT_W-1 -: VAL_W]),
		.a_row   (cmp_a[ROW_W-1:0]),
		.b_value (cmp_b[ENT_W-1 -: VAL_W]),
		.b_row   (cmp_b[ROW_W-1:0]),
		.a_less  (less)
	);

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = '0;
		wd      = carry_q;
		ra      = '0;
		rb      = '0;
		done    = 1'b0;
		cmp_a   = rd_b_q;
		cmp_b   = rd_a_q;
		case (state_q)
			H_IDLE: begin
				if (req.start) begin
					case (req.op)
						HOP_INSERT:  state_d = H_UP_RD;
						HOP_REPLACE: state_d = H_DN_RD;
						HOP_POP:     state_d = H_POP_RD;
						default:     state_d = H_IDLE;
					endcase
				end
			end
			H_POP_RD: begin
				// last entry becomes the hole filler
				ra      = n_q[IDX_W-1:0];
				state_d = H_POP_LD;
			end
			H_POP_LD: begin
				state_d = H_DN_RD;
			end
			H_DN_RD: begin
				if (has_l) begin
					ra      = l_ext[IDX_W-1:0];
					rb      = has_r ? r_ext[IDX_W-1:0] : l_ext[IDX_W-1:0];
					state_d = H_DN_C1;
				end else begin
					we      = 1'b1;
					wa      = i_q;
					done    = 1'b1;
					state_d = H_IDLE;
				end
			end
			H_DN_C1: begin
				// right child against left child
				state_d = H_DN_C2;
			end
			H_DN_C2: begin
				cmp_a = child_q;
				cmp_b = carry_q;
				we    = 1'b1;
				wa    = i_q;
				if (less) begin
					wd      = child_q;
					state_d = H_DN_RD;
				end else begin
					done    = 1'b1;
					state_d = H_IDLE;
				end
			end
			H_UP_RD: begin
				if (i_q == '0) begin
					we      = 1'b1;
					done    = 1'b1;
					state_d = H_IDLE;
				end else begin
					ra      = par;
					state_d = H_UP_C;
				end
			end
			H_UP_C: begin
				cmp_a = carry_q;
				cmp_b = rd_a_q;
				we    = 1'b1;
				wa    = i_q;
				if (less) begin
					wd      = rd_a_q;
					state_d = H_UP_RD;
				end else begin
					done    = 1'b1;
					state_d = H_IDLE;
				end
			end
			default: state_d = H_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			H_IDLE: begin
				if (req.start) begin
					carry_q <= {elem_value, elem_row};
					n_q     <= count;
					i_q     <= (req.op == HOP_INSERT) ? count[IDX_W-1:0] : '0;
				end
			end
			H_POP_LD: carry_q <= rd_a_q;
			H_DN_C1: begin
				if (has_r && less) begin
					child_q     <= rd_b_q;
					child_idx_q <= r_ext[IDX_W-1:0];
				end else begin
					child_q     <= rd_a_q;
					child_idx_q <= l_ext[IDX_W-1:0];
				end
			end
			H_DN_C2: begin
				if (less) begin
					i_q <= child_idx_q;
				end
			end
			H_UP_C: begin
				if (less) begin
					i_q <= par;
				end
			end
			default: ;
		endcase
	end

	// heap store, two registered read ports, root mirrored in a register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (we && (wa == '0)) begin
			root_q <= wd;
		end
		rd_a_q <= mem[ra];
		rd_b_q <= mem[rb];
	end

	assign stat.busy  = (state_q != H_IDLE);
	assign stat.done  = done;
	assign root_value = root_q[ENT_W-1 -: VAL_W];
	assign root_row   = root_q[ROW_W-1:0];

endmodule
`default_nettype wire

/* sim/kwm_merge_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kwm_merge_checker: result predictor and scoreboard for the k-way merge
// follows config writes and accepted requests with its own min-heap of list
// heads, queues the merged result of each request that yields one and
// compares every accepted result against the oldest queued one
// ----------------------------------------------------------------------------
module kwm_merge_checker import kwm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             item_valid,
	input  wire logic             item_ready,
	input  wire in_item_t         item,
	input  wire logic             result_valid,
	input  wire logic             result_ready,
	input  wire out_item_t        result,
	output int                    errors,
	output int                    pending
);

	localparam int HEAP_DEPTH = MAX_LISTS_DEF;
	localparam int REPORT_MAX = 10;

	logic signed [VAL_W-1:0] head_val [HEAP_DEPTH];
	logic [4:0]              head_row [HEAP_DEPTH];
	int                      heap_size;
	int                      loaded;
	logic [4:0]              row_due;
	bit                      merging;
	logic [CFG_W-1:0]        lists_cfg;
	out_item_t               merged_q [$];
	int                      reported;
	out_item_t               want;
	bit                      produced;

	// heap order: value first, lower list number wins a tie
	function automatic bit key_below(int a, int b);
		if (head_val[a] != head_val[b])
			return head_val[a] < head_val[b];
		return head_row[a] < head_row[b];
	endfunction

	function automatic int list_limit();
		if (lists_cfg == 0)
			return 1;
		if (lists_cfg > HEAP_DEPTH)
			return HEAP_DEPTH;
		return int'(lists_cfg);
	endfunction

	task automatic swap_heads(int a, int b);
		logic signed [VAL_W-1:0] tv;
		logic [4:0]              tr;
		tv = head_val[a];
		tr = head_row[a];
		head_val[a] = head_val[b];
		head_row[a] = head_row[b];
		head_val[b] = tv;
		head_row[b] = tr;
	endtask

	task automatic rise_from(int at);
		int up;
		bit moving;
		moving = 1'b1;
		while (moving && at > 0) begin
			up = (at - 1) / 2;
			if (!key_below(at, up)) begin
				moving = 1'b0;
			end else begin
				swap_heads(at, up);
				at = up;
			end
		end
	endtask

	task automatic settle_root();
		int at, lo, pick;
		bit moving;
		at = 0;
		moving = 1'b1;
		while (moving) begin
			lo = 2 * at + 1;
			pick = at;
			if (lo < heap_size && key_below(lo, pick))
				pick = lo;
			if (lo + 1 < heap_size && key_below(lo + 1, pick))
				pick = lo + 1;
			if (pick == at) begin
				moving = 1'b0;
			end else begin
				swap_heads(at, pick);
				at = pick;
			end
		end
	endtask

	task automatic merge_step(input in_item_t req, output bit has_out, output out_item_t res);
		has_out = 1'b0;
		res = '0;
		if (!merging) begin
			if (!req.exhausted && heap_size < HEAP_DEPTH) begin
				head_val[heap_size] = req.value;
				head_row[heap_size] = loaded[4:0];
				heap_size++;
				rise_from(heap_size - 1);
			end
			loaded++;
			if (loaded < list_limit())
				return;
		end else if (heap_size > 0) begin
			if (req.exhausted) begin
				heap_size--;
				head_val[0] = head_val[heap_size];
				head_row[0] = head_row[heap_size];
			end else begin
				head_val[0] = req.value;
				head_row[0] = row_due;
			end
			settle_root();
		end
		has_out = 1'b1;
		if (heap_size == 0) begin
			res.merge_done = 1'b1;
			merging = 1'b0;
			loaded = 0;
			row_due = '0;
		end else begin
			res.out_value = head_val[0];
			res.out_row = head_row[0][OUT_ROW_W-1:0];
			row_due = head_row[0];
			merging = 1'b1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_size = 0;
			loaded = 0;
			merging = 1'b0;
			row_due = '0;
			lists_cfg = NUM_LISTS_RST;
			merged_q.delete();
			errors = 0;
			reported = 0;
			pending = 0;
		end else begin
			if (cfg_we)
				lists_cfg = cfg_data;
			if (result_valid && result_ready) begin
				if (merged_q.size() == 0) begin
					errors++;
					if (reported < REPORT_MAX) begin
						reported++;
						$display("unexpected result: value %0d row %0d done %0b",
							result.out_value, result.out_row, result.merge_done);
					end
				end else begin
					want = merged_q.pop_front();
					if (result.out_value !== want.out_value ||
						result.out_row !== want.out_row ||
						result.merge_done !== want.merge_done) begin
						errors++;
						if (reported < REPORT_MAX) begin
							reported++;
							$display("result mismatch: expected value %0d row %0d done %0b,",
								want.out_value, want.out_row, want.merge_done,
								" got value %0d row %0d done %0b",
								result.out_value, result.out_row, result.merge_done);
						end
					end
				end
			end
			if (item_valid && item_ready) begin
				merge_step(item, produced, want);
				if (produced)
					merged_q = {merged_q, want};
			end
			pending = merged_q.size();
		end
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the k-way sorted merge
// feeds whole merges (load phase, then the next element of whichever list
// the last result named) built from sorted, tied, extreme and shuffled lists,
// sweeps num_lists between merges, and varies sender gaps and receiver stalls
// ----------------------------------------------------------------------------
module tb_top;
	import kwm_pkg::*;

	localparam int ITEM_TARGET   = 1450;
	localparam int QUIET_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 40;
	localparam int LIST_SLOTS    = MAX_LISTS_DEF;
	localparam int LIST_DEPTH    = 16;

	typedef enum int {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH
	} pace_t;

	typedef enum int {
		LIST_SPREAD,
		LIST_TIES,
		LIST_WIDE,
		LIST_EXTREMES,
		LIST_SHUFFLED
	} list_kind_t;

	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             cfg_we       = 1'b0;
	logic [CFG_W-1:0] cfg_data     = '0;
	logic             item_valid   = 1'b0;
	in_item_t         item         = '0;
	logic             item_ready;
	logic             result_valid;
	logic             result_ready = 1'b0;
	out_item_t        result;

	int errors;
	int pending;

	// handshake bookkeeping seen from the stimulus side
	bit        item_taken;
	out_item_t taken_log [$];
	int        results_owed = 0;
	int        items_sent   = 0;
	int        quiet        = 0;

	// pacing knobs, percent per cycle
	int idle_pct  = 0;
	int stall_pct = 0;

	// lists of the merge in flight
	int                      list_count = MAX_LISTS_DEF;
	logic signed [VAL_W-1:0] list_val [LIST_SLOTS][LIST_DEPTH];
	int                      list_len [LIST_SLOTS];
	int                      list_pos [LIST_SLOTS];

	always #5 clk = ~clk;

	k_way_sorted_merge u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	kwm_merge_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.errors       (errors),
		.pending      (pending)
	);

	// sample both channels at the rising edge; the watchdog counts cycles
	// in which neither channel moves anything
	always @(posedge clk) begin
		item_taken <= item_valid && item_ready;
		if (result_valid && result_ready)
			taken_log = {taken_log, result};
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// receiver back-pressure, redrawn every cycle
	always @(negedge clk) begin
		result_ready = ($urandom_range(99) >= stall_pct);
	end

	task automatic set_pace(pace_t p);
		case (p)
			PACE_FULL: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			PACE_SEND_GAPS: begin
				idle_pct = 45;
				stall_pct = 0;
			end
			PACE_RECV_STALLS: begin
				idle_pct = 0;
				stall_pct = 45;
			end
			default: begin
				idle_pct = 8;
				stall_pct = 8;
			end
		endcase
	endtask

	// one request: optional gap, then hold valid until it is taken
	task automatic send_request(input logic signed [VAL_W-1:0] v, input logic gone);
		while ($urandom_range(99) < idle_pct)
			@(negedge clk);
		item_valid = 1'b1;
		item.value = v;
		item.exhausted = gone;
		@(negedge clk);
		while (!item_taken)
			@(negedge clk);
		item_valid = 1'b0;
		items_sent++;
	endtask

	// result of the request just sent: read it off the bus while it waits,
	// or from the log if the receiver already took it
	task automatic await_result(output out_item_t r);
		int idx;
		idx = results_owed;
		results_owed++;
		while (taken_log.size() <= idx && !(taken_log.size() == idx && result_valid))
			@(negedge clk);
		if (taken_log.size() > idx)
			r = taken_log[idx];
		else
			r = result;
	endtask

	// config only while the block sits idle with nothing owed
	task automatic write_list_count(input logic [CFG_W-1:0] v);
		while (pending != 0 || taken_log.size() < results_owed)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we = 1'b1;
		cfg_data = v;
		@(negedge clk);
		cfg_we = 1'b0;
		if (v == 0)
			list_count = 1;
		else if (v > MAX_LISTS_DEF)
			list_count = MAX_LISTS_DEF;
		else
			list_count = int'(v);
	endtask

	function automatic logic signed [VAL_W-1:0] rim_value(int i);
		case (i)
			0: return 32'sh8000_0000;
			1: return 32'sh8000_0001;
			2: return -32'sd1;
			3: return 32'sd0;
			4: return 32'sd1;
			5: return 32'sh7fff_fffe;
			default: return 32'sh7fff_ffff;
		endcase
	endfunction

	function automatic list_kind_t pick_kind();
		int w;
		w = $urandom_range(99);
		if (w < 30)
			return LIST_SPREAD;
		if (w < 55)
			return LIST_TIES;
		if (w < 75)
			return LIST_WIDE;
		if (w < 85)
			return LIST_EXTREMES;
		return LIST_SHUFFLED;
	endfunction

	// random lists for one merge; rows past the count stay empty
	task automatic build_lists(int count);
		list_kind_t kind;
		longint     acc;
		int         s, k, rim;
		for (s = 0; s < LIST_SLOTS; s++) begin
			list_len[s] = 0;
			if (s < count) begin
				kind = pick_kind();
				if ($urandom_range(9) == 0)
					list_len[s] = $urandom_range(LIST_DEPTH);
				else
					list_len[s] = $urandom_range(6);
				case (kind)
					LIST_SPREAD: acc = longint'($urandom_range(2000)) - 1000;
					LIST_TIES: acc = $urandom_range(3);
					LIST_WIDE: acc = longint'($signed($urandom));
					default: acc = 0;
				endcase
				rim = $urandom_range(3);
				for (k = 0; k < list_len[s]; k++) begin
					case (kind)
						LIST_SPREAD: acc = acc + $urandom_range(100);
						LIST_TIES: acc = acc + $urandom_range(1);
						LIST_WIDE: acc = acc + $urandom_range(32'h0800_0000);
						default: acc = acc;
					endcase
					if (acc > 64'sd2147483647)
						acc = 64'sd2147483647;
					if (kind == LIST_EXTREMES) begin
						list_val[s][k] = rim_value(rim);
						rim = rim + $urandom_range(1);
						if (rim > 6)
							rim = 6;
					end else if (kind == LIST_SHUFFLED) begin
						// out-of-order content, still taken by key
						list_val[s][k] = $signed($urandom);
					end else begin
						list_val[s][k] = acc[VAL_W-1:0];
					end
				end
			end
		end
	endtask

	// one whole merge: load every list head, then follow the rows named by
	// the results until merge_done
	task automatic run_merge();
		out_item_t               r;
		logic signed [VAL_W-1:0] v;
		int                      s, row, guard;
		for (s = 0; s < list_count; s++) begin
			if (list_len[s] > 0) begin
				list_pos[s] = 1;
				send_request(list_val[s][0], 1'b0);
			end else begin
				list_pos[s] = 0;
				send_request($signed($urandom), 1'b1);
			end
		end
		// the last load request ends the load phase
		await_result(r);
		guard = 0;
		while (!r.merge_done && guard < 300) begin
			row = int'(r.out_row);
			if (list_pos[row] < list_len[row]) begin
				v = list_val[row][list_pos[row]];
				list_pos[row]++;
				send_request(v, 1'b0);
			end else begin
				send_request($signed($urandom), 1'b1);
			end
			await_result(r);
			guard++;
		end
	endtask

	function automatic logic [CFG_W-1:0] pick_list_count();
		int w;
		w = $urandom_range(19);
		case (w)
			0: return '0;
			1: return CFG_W'($urandom_range(31, MAX_LISTS_DEF + 1));
			2: return CFG_W'(MAX_LISTS_DEF);
			3: return CFG_W'(1);
			default: return CFG_W'($urandom_range(MAX_LISTS_DEF, 2));
		endcase
	endfunction

	initial begin
		int merges;
		int s;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		set_pace(PACE_FULL);

		// zero count acts as one list; both ends of the value range
		write_list_count('0);
		list_len[0] = 2;
		list_val[0][0] = 32'sh8000_0000;
		list_val[0][1] = 32'sh7fff_ffff;
		run_merge();

		// single list empty at load end: done right away
		write_list_count(CFG_W'(1));
		list_len[0] = 0;
		run_merge();

		// three lists with ties across rows and an out-of-order element
		write_list_count(CFG_W'(3));
		list_len[0] = 2;
		list_val[0][0] = 32'sd7;
		list_val[0][1] = 32'sd2;
		list_len[1] = 2;
		list_val[1][0] = 32'sd5;
		list_val[1][1] = 32'sd5;
		list_len[2] = 1;
		list_val[2][0] = 32'sd5;
		run_merge();

		// count above the maximum clamps; every list empty
		write_list_count(CFG_W'(31));
		for (s = 0; s < LIST_SLOTS; s++)
			list_len[s] = 0;
		run_merge();

		// random merges, pacing rotated every few merges
		merges = 0;
		while (items_sent < ITEM_TARGET) begin
			set_pace(pace_t'((merges / 3) % 4));
			if ($urandom_range(9) < 6)
				write_list_count(pick_list_count());
			build_lists(list_count);
			run_merge();
			merges++;
		end

		// drain, then wait idle for any stray result
		while (pending != 0 || taken_log.size() < results_owed)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
